### hw/rtl/mf11_pkg.sv
// Shared types for the 11-tap median despike filter.
`default_nettype none
package mf11_pkg;

	typedef struct packed {
		logic load;
		logic use_norm;
		logic use_median;
		logic last;
	} emit_t;

endpackage
`default_nettype wire

### hw/rtl/median11_profile_despike.sv
// Top level of the streaming 11-tap median despike filter.
//
//   channel | handshake                    | payload
//   --------+------------------------------+-------------------------------
//   input   | sample_valid / sample_stall  | sample, last_in
//   output  | result_valid / result_stall  | value, was_filtered, last_out
//
// One sample per cycle while sample_stall is low: the sorted cell chain inserts the new
// sample and drops the oldest in the cycle it is taken. Results trail inputs by HALF_WINDOW
// samples; a result passes the sequencer and then the output register before it leaves.
// A last sample adds up to HALF_WINDOW drain results, one per cycle while result_stall is
// low; sample_stall stays high until the final one is sent.
// Reset clears the chain to zeros and starts a new profile.
`default_nettype none
module median11_profile_despike #(
	parameter int HALF_WINDOW = 5,
	parameter int SAMPLE_BITS = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           sample_valid,
	output logic                          sample_stall,
	input  wire signed [SAMPLE_BITS-1:0]  sample,
	input  wire                           last_in,
	output logic                          result_valid,
	input  wire                           result_stall,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic                          was_filtered,
	output logic                          last_out
);

	localparam int WIN      = 2 * HALF_WINDOW + 1;
	localparam int AGE_BITS = $clog2(WIN);
	localparam int CNT_BITS = $clog2(WIN + 1);
	localparam int IDX_BITS = $clog2(HALF_WINDOW + 1);

	logic signed [SAMPLE_BITS-1:0] val_w   [WIN];
	logic        [AGE_BITS-1:0]    age_w   [WIN];
	logic                          lt_w    [WIN];
	logic signed [SAMPLE_BITS-1:0] c_val_w [WIN];
	logic        [AGE_BITS-1:0]    c_age_w [WIN];
	logic                          cl_w    [WIN];
	logic                          pre_w   [WIN];

	logic signed [SAMPLE_BITS-1:0] tap_q [HALF_WINDOW+1];

	mf11_pkg::emit_t       emit;
	logic [IDX_BITS-1:0]   drain_idx;
	logic                  in_ready;
	logic                  accept;
	logic                  out_free;
	logic signed [SAMPLE_BITS-1:0] nxt_value;

	logic signed [SAMPLE_BITS-1:0] value_q;
	logic                          filt_q;
	logic                          last_q;
	logic                          valid_q;

	assign sample_stall = !in_ready;
	assign accept       = sample_valid & in_ready;
	assign out_free     = !valid_q | !result_stall;

	mf11_seq #(
		.HALF_WINDOW (HALF_WINDOW),
		.WIN         (WIN),
		.CNT_BITS    (CNT_BITS),
		.IDX_BITS    (IDX_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_last   (last_in),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.emit      (emit),
		.drain_idx (drain_idx)
	);

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] r_val;
		logic        [AGE_BITS-1:0]    r_age;
		logic                          r_lt;
		logic signed [SAMPLE_BITS-1:0] l_val;
		logic        [AGE_BITS-1:0]    l_age;
		logic                          l_cl;
		logic                          l_pre;

		if (i < WIN - 1) begin : g_right
			assign r_val = val_w[i+1];
			assign r_age = age_w[i+1];
			assign r_lt  = lt_w[i+1];
		end else begin : g_end
			assign r_val = val_w[i];
			assign r_age = age_w[i];
			assign r_lt  = 1'b0;
		end

		if (i > 0) begin : g_left
			assign l_val = c_val_w[i-1];
			assign l_age = c_age_w[i-1];
			assign l_cl  = cl_w[i-1];
			assign l_pre = pre_w[i-1];
		end else begin : g_head
			assign l_val = sample;
			assign l_age = '0;
			assign l_cl  = 1'b1;
			assign l_pre = 1'b0;
		end

		mf11_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_BITS    (AGE_BITS),
			.OLDEST      (WIN - 1),
			.INIT_AGE    (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.x          (sample),
			.right_val  (r_val),
			.right_age  (r_age),
			.right_lt   (r_lt),
			.left_c_val (l_val),
			.left_c_age (l_age),
			.left_cl    (l_cl),
			.prefix_in  (l_pre),
			.val        (val_w[i]),
			.age        (age_w[i]),
			.lt         (lt_w[i]),
			.c_val      (c_val_w[i]),
			.c_age      (c_age_w[i]),
			.cl         (cl_w[i]),
			.prefix_out (pre_w[i])
		);
	end

	// raw delay line, newest first
	always_ff @(posedge clk) begin
		if (accept) begin
			tap_q[0] <= sample;
			for (int k = 1; k <= HALF_WINDOW; k++) begin
				tap_q[k] <= tap_q[k-1];
			end
		end
	end

	always_comb begin
		if (emit.use_norm) begin
			nxt_value = emit.use_median ? val_w[HALF_WINDOW] : tap_q[HALF_WINDOW];
		end else begin
			nxt_value = tap_q[drain_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= emit.load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.load) begin
			value_q <= nxt_value;
			filt_q  <= emit.use_median;
			last_q  <= emit.last;
		end
	end

	assign result_valid = valid_q;
	assign value        = value_q;
	assign was_filtered = filt_q;
	assign last_out     = last_q;

endmodule
`default_nettype wire

### hw/rtl/mf11_cell.sv
// One cell of the sorted window chain: holds a sample and its age.
`default_nettype none
module mf11_cell #(
	parameter int SAMPLE_BITS = 32,
	parameter int AGE_BITS    = 4,
	parameter int OLDEST      = 10,
	parameter int INIT_AGE    = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire signed [SAMPLE_BITS-1:0] x,
	input  wire signed [SAMPLE_BITS-1:0] right_val,
	input  wire        [AGE_BITS-1:0]    right_age,
	input  wire                          right_lt,
	input  wire signed [SAMPLE_BITS-1:0] left_c_val,
	input  wire        [AGE_BITS-1:0]    left_c_age,
	input  wire                          left_cl,
	input  wire                          prefix_in,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic       [AGE_BITS-1:0]    age,
	output logic                         lt,
	output logic signed [SAMPLE_BITS-1:0] c_val,
	output logic       [AGE_BITS-1:0]    c_age,
	output logic                         cl,
	output logic                         prefix_out
);

	localparam logic [AGE_BITS-1:0] OLDEST_AGE = AGE_BITS'(OLDEST);
	localparam logic [AGE_BITS-1:0] RESET_AGE  = AGE_BITS'(INIT_AGE);

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic        [AGE_BITS-1:0]    age_q;
	logic signed [SAMPLE_BITS-1:0] nxt_val;
	logic        [AGE_BITS-1:0]    nxt_age;

	assign val        = val_q;
	assign age        = age_q;
	assign lt         = val_q < x;
	assign prefix_out = prefix_in | (age_q == OLDEST_AGE);

	// close the gap left by the oldest entry
	always_comb begin
		if (prefix_out) begin
			c_val = right_val;
			c_age = right_age;
			cl    = right_lt;
		end else begin
			c_val = val_q;
			c_age = age_q;
			cl    = lt;
		end
	end

	// insert the new sample in order
	always_comb begin
		if (cl) begin
			nxt_val = c_val;
			nxt_age = c_age + AGE_BITS'(1);
		end else if (left_cl) begin
			nxt_val = x;
			nxt_age = '0;
		end else begin
			nxt_val = left_c_val;
			nxt_age = left_c_age + AGE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= RESET_AGE;
		end else if (en) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/mf11_seq.sv
// Profile position counter and result sequencer for the despike filter.
`default_nettype none
module mf11_seq #(
	parameter int HALF_WINDOW = 5,
	parameter int WIN         = 11,
	parameter int CNT_BITS    = 4,
	parameter int IDX_BITS    = 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_last,
	input  wire                   out_free,
	output logic                  in_ready,
	output mf11_pkg::emit_t       emit,
	output logic [IDX_BITS-1:0]   drain_idx
);

	localparam logic [CNT_BITS-1:0] HALF_C = CNT_BITS'(HALF_WINDOW);
	localparam logic [CNT_BITS-1:0] WIN_C  = CNT_BITS'(WIN);
	localparam logic [IDX_BITS-1:0] HALF_D = IDX_BITS'(HALF_WINDOW);

	logic [CNT_BITS-1:0] seen_q;
	logic                norm_q;
	logic                full_q;
	logic                last_q;
	logic [IDX_BITS-1:0] drain_q;
	logic                has_pend;
	logic                final_one;
	logic                fire;
	logic                accept;
	logic [CNT_BITS-1:0] n;

	assign has_pend  = norm_q | (drain_q != '0);
	assign final_one = norm_q ? (drain_q == '0) : (drain_q == IDX_BITS'(1));
	assign fire      = has_pend & out_free;
	assign in_ready  = !has_pend | (fire & final_one);
	assign accept    = in_valid & in_ready;
	assign n         = (seen_q == WIN_C) ? WIN_C : seen_q + CNT_BITS'(1);
	assign drain_idx = drain_q - IDX_BITS'(1);

	always_comb begin
		emit.load       = fire;
		emit.use_norm   = norm_q;
		emit.use_median = norm_q & full_q;
		emit.last       = last_q & final_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			norm_q  <= 1'b0;
			full_q  <= 1'b0;
			last_q  <= 1'b0;
			drain_q <= '0;
		end else if (accept) begin
			norm_q <= n > HALF_C;
			full_q <= n == WIN_C;
			last_q <= in_last;
			seen_q <= in_last ? '0 : n;
			if (in_last) begin
				drain_q <= (n < HALF_C) ? IDX_BITS'(n) : HALF_D;
			end else begin
				drain_q <= '0;
			end
		end else if (fire) begin
			if (norm_q) begin
				norm_q <= 1'b0;
			end else begin
				drain_q <= drain_q - IDX_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for the 11-tap median despike filter: streams profiles and checks each result.
`timescale 1ns / 100ps

module testbench;

	localparam int HALF = 5;
	localparam int WIN = 2 * HALF + 1;
	localparam int LIMIT = 200000;

	typedef struct packed {
		logic pause;
		logic signed [31:0] height;
		logic last;
	} sample_item_t;

	typedef struct packed {
		logic signed [31:0] level;
		logic filtered;
		logic last;
	} despiked_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [31:0] sample = '0;
	logic last_in = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] value;
	logic was_filtered;
	logic last_out;

	sample_item_t profile_q[$];
	despiked_t despiked_q[$];

	logic signed [31:0] taps [0:WIN-1];
	int taken_count = 0;
	logic took_sample = 1'b0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatches = 0;
	int cycle_count = 0;

	median11_profile_despike #(
		.HALF_WINDOW(HALF),
		.SAMPLE_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.last_in(last_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.value(value),
		.was_filtered(was_filtered),
		.last_out(last_out)
	);

	always #2 clk = ~clk;

	function automatic logic signed [31:0] window_median();
		logic signed [31:0] sorted [0:WIN-1];
		logic signed [31:0] v;
		int j;
		for (int i = 0; i < WIN; i++)
			sorted[i] = taps[i];
		for (int i = 1; i < WIN; i++) begin
			v = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > v) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = v;
		end
		return sorted[HALF];
	endfunction

	task automatic despike_step(input logic signed [31:0] s, input logic last);
		despiked_t res [0:HALF];
		int count;
		int drain;
		count = 0;
		for (int i = WIN - 1; i > 0; i--)
			taps[i] = taps[i - 1];
		taps[0] = s;
		if (taken_count < WIN)
			taken_count++;
		if (taken_count > HALF) begin
			if (taken_count >= WIN)
				res[count] = '{level: window_median(), filtered: 1'b1, last: 1'b0};
			else
				res[count] = '{level: taps[HALF], filtered: 1'b0, last: 1'b0};
			count++;
		end
		if (last) begin
			drain = (taken_count < HALF) ? taken_count : HALF;
			for (int k = drain - 1; k >= 0; k--) begin
				res[count] = '{level: taps[k], filtered: 1'b0, last: 1'b0};
				count++;
			end
			if (count > 0)
				res[count - 1].last = 1'b1;
			taken_count = 0;
		end
		for (int i = 0; i < count; i++)
			despiked_q.insert(despiked_q.size(), res[i]);
	endtask

	task automatic add_sample(input logic signed [31:0] s, input logic last);
		sample_item_t item;
		item = '{pause: 1'b0, height: s, last: last};
		profile_q.insert(profile_q.size(), item);
	endtask

	task automatic add_pause();
		sample_item_t item;
		item = '{pause: 1'b1, height: '0, last: 1'b0};
		profile_q.insert(profile_q.size(), item);
	endtask

	function automatic logic signed [31:0] profile_sample(input logic signed [31:0] base);
		case ($urandom_range(0, 19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return base + ($urandom_range(0, 40) - 20);
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		despiked_t got;
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			took_sample = arst_n && sample_valid && !sample_stall;
			if (took_sample)
				despike_step(sample, last_in);
			if (arst_n && result_valid && !result_stall) begin
				got = '{level: value, filtered: was_filtered, last: last_out};
				checked_count++;
				if (despiked_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %0d filtered %0b last %0b",
							got.level, got.filtered, got.last);
				end else if (got != despiked_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							despiked_q[0].level, despiked_q[0].filtered, despiked_q[0].last,
							got.level, got.filtered, got.last);
					void'(despiked_q.pop_front());
				end else begin
					void'(despiked_q.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin : driver
		sample_item_t item;
		logic next_valid;
		logic calm;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!(sample_valid && !took_sample)) begin
			next_valid = 1'b0;
			calm = sent_count >= 150 && sent_count < 250;
			if (profile_q.size() > 0 && profile_q[0].pause && despiked_q.size() == 0)
				void'(profile_q.pop_front());
			if (profile_q.size() > 0 && !profile_q[0].pause &&
					(calm || $urandom_range(0, 99) >= 27)) begin
				item = profile_q.pop_front();
				sample <= item.height;
				last_in <= item.last;
				next_valid = 1'b1;
				sent_count++;
			end
			sample_valid <= next_valid;
		end
	end

	always @(negedge clk) begin : sink
		if (!arst_n || (checked_count >= 150 && checked_count < 260))
			result_stall <= 1'b0;
		else
			result_stall <= $urandom_range(0, 99) < 27;
	end

	initial begin : stimulus
		int len;
		int random_items;
		logic signed [31:0] base;
		for (int i = 0; i < WIN; i++)
			taps[i] = '0;

		add_sample(32'sh7fffffff, 1'b1);

		add_sample(32'sh80000000, 1'b0);
		add_sample(32'sh7fffffff, 1'b0);
		add_sample(32'sh00000000, 1'b0);
		add_sample(-32'sd1, 1'b0);
		add_sample(32'sd1, 1'b1);

		add_sample(32'sh55555555, 1'b0);
		add_sample(32'shaaaaaaaa, 1'b0);
		add_sample(32'sd7, 1'b0);
		add_sample(-32'sd7, 1'b0);
		add_sample(32'sd0, 1'b0);
		add_sample(32'sd3, 1'b1);

		add_sample(32'sd10, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sh7fffffff, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sh80000000, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(-32'sd3, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sd10, 1'b0);
		add_sample(32'sd7, 1'b1);
		add_pause();

		random_items = 0;
		while (random_items < 300) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, 4);
				1: len = $urandom_range(5, 10);
				2: len = $urandom_range(11, 12);
				3: len = $urandom_range(40, 90);
				default: len = $urandom_range(13, 30);
			endcase
			base = $urandom_range(0, 2097152) - 1048576;
			for (int k = 0; k < len; k++)
				add_sample(profile_sample(base), k == len - 1);
			random_items += len;
			if ($urandom_range(0, 7) == 0)
				add_pause();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (profile_q.size() != 0 || sample_valid)
			@(posedge clk);
		while (despiked_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
hw/rtl/mf11_pkg.sv
hw/rtl/mf11_cell.sv
hw/rtl/mf11_seq.sv
hw/rtl/median11_profile_despike.sv
sim/testbench.sv
